// ----- design/hic_pkg.sv -----
// Shared types and constants for the homography inlier classifier.
// Word layouts, arithmetic widths, register indexes and adjugate index tables.
// No dependencies.
`default_nettype none
package hic_pkg;

    localparam int COORD_BITS = 12;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ERR_W      = 32;

    localparam int PROD_W  = COEF_W + COORD_BITS + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = SUM_W;
    localparam int NUM_W   = MAG_W + 9;
    localparam int Q_BITS  = 26;
    localparam int CMP_W   = MAG_W + Q_BITS;
    localparam int TGT_W   = COORD_BITS + 8;
    localparam int D_W     = ((TGT_W > Q_BITS) ? TGT_W : Q_BITS) + 2;
    localparam int CLAMP_W = 25;
    localparam int SQ_W    = 2 * CLAMP_W;
    localparam int ACC_W   = SQ_W + 2;

    localparam int PROJ_LAT = 2;
    localparam int DIV_LAT  = Q_BITS + 1;
    localparam int ERR_LAT  = 3;
    localparam int PIPE_LAT = PROJ_LAT + DIV_LAT + ERR_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAIR0  = 3'd0,
        REG_PAIR1  = 3'd1,
        REG_PAIR2  = 3'd2,
        REG_PAIR3  = 3'd3,
        REG_LAST   = 3'd4,
        REG_THRESH = 3'd5
    } reg_idx_t;

    localparam logic [CFG_DATA_W-1:0] RST_PAIR_DIAG = 64'h0001_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_PAIR_ZERO = 64'h0;
    localparam logic [COEF_W-1:0]     RST_LAST      = 32'h0001_0000;
    localparam logic [ERR_W-1:0]      RST_THRESH    = 32'd1024;

    // cofactor j = h[PA]*h[PB] - h[QA]*h[QB]
    localparam int CF_PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_QA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_QB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [8:0] mat_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
    } in_word_t;

    typedef struct packed {
        logic             inlier;
        logic [ERR_W-1:0] squared_error;
    } out_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] w;
    } proj_t;

    typedef struct packed {
        logic              neg;
        logic [Q_BITS-1:0] mag;
    } quot_t;

    typedef quot_t [3:0] quot4_t;
    typedef logic [3:0][COORD_BITS-1:0] tgt4_t;

endpackage
`default_nettype wire

// ----- design/homography_inlier_classifier_core.sv -----
// Top level of the homography inlier classifier.
// Depends on hic_pkg, hic_coeff, hic_project, hic_qdiv and hic_error.
//
// Usage:
//   s_valid/s_ready/s_data carry one point correspondence per word.
//   m_valid/m_ready/m_data return one word per correspondence, in order:
//   the saturated Q24.8 symmetric transfer error and the inlier flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the homography coefficients
//   and the threshold; cfg_ready is always high. Write only while idle.
//   Throughput: one word per cycle unless stalled; every stage is fully pipelined,
//   including the 27-stage divider (a setup stage, then one quotient bit per stage).
//   After reset and after every configuration write, s_ready stays low while
//   the adjugate pipeline recomputes from the registers.
//   Reset loads the identity homography and a threshold of 1024.
//   When the receiver stalls, the whole pipeline holds and s_ready drops;
//   nothing is dropped or repeated.
`default_nettype none
module homography_inlier_classifier_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  hic_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output hic_pkg::out_word_t                  m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hic_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hic_pkg::*;

    mat_t             h;
    mat_t             g;
    logic [ERR_W-1:0] thr;
    logic             coef_busy;
    logic             adv;

    logic                  in_valid_reg;
    in_word_t              in_reg;
    logic [PIPE_LAT-1:0]   vld_reg;
    in_word_t              crd_reg [PROJ_LAT+DIV_LAT];
    logic [DIV_LAT-1:0]    z_reg;
    logic                  m_valid_reg;
    out_word_t             m_data_reg;

    proj_t     p1;
    proj_t     p2;
    quot4_t    pq;
    tgt4_t     tgt;
    out_word_t res;
    in_word_t  tw;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !coef_busy;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    hic_coeff u_coeff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .h         (h),
        .g         (g),
        .thr       (thr),
        .busy      (coef_busy)
    );

    hic_project u_proj_fwd (
        .aclk (aclk), .en (adv), .m (h),
        .u (in_reg.second_x), .v (in_reg.second_y), .p (p1)
    );

    hic_project u_proj_inv (
        .aclk (aclk), .en (adv), .m (g),
        .u (in_reg.first_x), .v (in_reg.first_y), .p (p2)
    );

    hic_qdiv u_div_x1 (.aclk (aclk), .en (adv), .num (p1.x), .den (p1.w), .q (pq[0]));
    hic_qdiv u_div_y1 (.aclk (aclk), .en (adv), .num (p1.y), .den (p1.w), .q (pq[1]));
    hic_qdiv u_div_x2 (.aclk (aclk), .en (adv), .num (p2.x), .den (p2.w), .q (pq[2]));
    hic_qdiv u_div_y2 (.aclk (aclk), .en (adv), .num (p2.y), .den (p2.w), .q (pq[3]));

    assign tw     = crd_reg[PROJ_LAT+DIV_LAT-1];
    assign tgt[0] = tw.first_x;
    assign tgt[1] = tw.first_y;
    assign tgt[2] = tw.second_x;
    assign tgt[3] = tw.second_y;

    hic_error u_err (
        .aclk (aclk), .en (adv), .pq (pq), .tgt (tgt),
        .zero (z_reg[DIV_LAT-1]), .thr (thr), .res (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid && s_ready;
            vld_reg      <= {vld_reg[PIPE_LAT-2:0], in_valid_reg};
            m_valid_reg  <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg     <= s_data;
            crd_reg[0] <= in_reg;
            for (int i = 1; i < PROJ_LAT + DIV_LAT; i++) begin
                crd_reg[i] <= crd_reg[i-1];
            end
            z_reg      <= {z_reg[DIV_LAT-2:0], (p1.w == '0) || (p2.w == '0)};
            m_data_reg <= res;
        end
    end

    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("input accepted right after a coefficient write");

    a_inlier_below_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.inlier |-> (m_data.squared_error < thr))
        else $error("inlier flagged at or above threshold");

    a_inlier_not_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.inlier |-> (m_data.squared_error != '1))
        else $error("inlier flagged with saturated error");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> (vld_reg == $past(vld_reg)) && m_valid)
        else $error("pipeline moved during output stall");

endmodule
`default_nettype wire

// ----- design/hic_coeff.sv -----
// Coefficient registers and two-stage adjugate pipeline.
// Depends on hic_pkg.
`default_nettype none
module hic_coeff (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hic_pkg::CFG_DATA_W-1:0] cfg_data,
    output hic_pkg::mat_t                       h,
    output hic_pkg::mat_t                       g,
    output logic [hic_pkg::ERR_W-1:0]           thr,
    output logic                                busy
);
    import hic_pkg::*;

    logic [CFG_DATA_W-1:0] pair_reg [4];
    logic [COEF_W-1:0]     last_reg;
    logic [ERR_W-1:0]      thr_reg;
    logic [1:0]            cnt_reg;

    logic signed [2*COEF_W-1:0] pp_reg [9];
    logic signed [2*COEF_W-1:0] qp_reg [9];
    coef_t                      g_reg  [9];

    assign cfg_ready = 1'b1;
    assign busy      = (cnt_reg != 2'd0);
    assign thr       = thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg[0] <= RST_PAIR_DIAG;
            pair_reg[1] <= RST_PAIR_ZERO;
            pair_reg[2] <= RST_PAIR_DIAG;
            pair_reg[3] <= RST_PAIR_ZERO;
            last_reg    <= RST_LAST;
            thr_reg     <= RST_THRESH;
            cnt_reg     <= 2'd2;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PAIR0:  pair_reg[0] <= cfg_data;
                REG_PAIR1:  pair_reg[1] <= cfg_data;
                REG_PAIR2:  pair_reg[2] <= cfg_data;
                REG_PAIR3:  pair_reg[3] <= cfg_data;
                REG_LAST:   last_reg    <= cfg_data[COEF_W-1:0];
                REG_THRESH: thr_reg     <= cfg_data[ERR_W-1:0];
                default:    ;
            endcase
            cnt_reg <= 2'd2;
        end else if (cnt_reg != 2'd0) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            h[2*i]   = pair_reg[i][2*COEF_W-1:COEF_W];
            h[2*i+1] = pair_reg[i][COEF_W-1:0];
        end
        h[8] = last_reg;
    end

    for (genvar j = 0; j < 9; j++) begin : g_cof
        logic signed [2*COEF_W:0]    diff;
        logic signed [2*COEF_W:0]    shr;
        logic                        fits;
        coef_t                       sat;

        always_ff @(posedge aclk) begin
            pp_reg[j] <= (2*COEF_W)'(h[CF_PA[j]]) * (2*COEF_W)'(h[CF_PB[j]]);
            qp_reg[j] <= (2*COEF_W)'(h[CF_QA[j]]) * (2*COEF_W)'(h[CF_QB[j]]);
            g_reg[j]  <= sat;
        end

        always_comb begin
            diff = {pp_reg[j][2*COEF_W-1], pp_reg[j]} - {qp_reg[j][2*COEF_W-1], qp_reg[j]};
            shr  = diff >>> 16;
            fits = (shr[2*COEF_W:COEF_W-1] == '0) || (shr[2*COEF_W:COEF_W-1] == '1);
            if (fits) begin
                sat = shr[COEF_W-1:0];
            end else if (shr[2*COEF_W]) begin
                sat = {1'b1, {(COEF_W-1){1'b0}}};
            end else begin
                sat = {1'b0, {(COEF_W-1){1'b1}}};
            end
        end

        assign g[j] = g_reg[j];
    end

endmodule
`default_nettype wire

// ----- design/hic_project.sv -----
// Two-stage projection of a pixel through a 3x3 matrix: products, then row sums.
// Depends on hic_pkg.
`default_nettype none
module hic_project (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  hic_pkg::mat_t                        m,
    input  wire logic [hic_pkg::COORD_BITS-1:0]  u,
    input  wire logic [hic_pkg::COORD_BITS-1:0]  v,
    output hic_pkg::proj_t                       p
);
    import hic_pkg::*;

    logic signed [PROD_W-1:0] pu_reg [3];
    logic signed [PROD_W-1:0] pv_reg [3];
    coef_t                    c_reg  [3];
    logic signed [SUM_W-1:0]  s_reg  [3];

    logic signed [COORD_BITS:0] su;
    logic signed [COORD_BITS:0] sv;

    assign su = $signed({1'b0, u});
    assign sv = $signed({1'b0, v});

    for (genvar r = 0; r < 3; r++) begin : g_row
        always_ff @(posedge aclk) begin
            if (en) begin
                pu_reg[r] <= PROD_W'(m[3*r]) * PROD_W'(su);
                pv_reg[r] <= PROD_W'(m[3*r+1]) * PROD_W'(sv);
                c_reg[r]  <= m[3*r+2];
                s_reg[r]  <= SUM_W'(pu_reg[r]) + SUM_W'(pv_reg[r]) + SUM_W'(c_reg[r]);
            end
        end
    end

    assign p.x = s_reg[0];
    assign p.y = s_reg[1];
    assign p.w = s_reg[2];

endmodule
`default_nettype wire

// ----- design/hic_qdiv.sv -----
// Pipelined restoring divider: round(num*256/den) magnitude, saturated, one bit per stage.
// Depends on hic_pkg.
`default_nettype none
module hic_qdiv (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic signed [hic_pkg::SUM_W-1:0]   num,
    input  wire logic signed [hic_pkg::SUM_W-1:0]   den,
    output hic_pkg::quot_t                          q
);
    import hic_pkg::*;

    logic [NUM_W-1:0]  r_reg [Q_BITS+1];
    logic [MAG_W-1:0]  d_reg [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg [Q_BITS+1];
    logic              n_reg [Q_BITS+1];

    logic [MAG_W-1:0] un;
    logic [MAG_W-1:0] ud;

    assign un = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    assign ud = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0] <= NUM_W'({un, 8'b0}) + NUM_W'(ud >> 1);
            d_reg[0] <= ud;
            q_reg[0] <= '0;
            n_reg[0] <= num[SUM_W-1] ^ den[SUM_W-1];
        end
    end

    for (genvar j = 1; j <= Q_BITS; j++) begin : g_bit
        localparam int K = Q_BITS - j;
        logic [CMP_W-1:0] sh;
        logic             ge;

        assign sh = CMP_W'(d_reg[j-1]) << K;
        assign ge = (CMP_W'(r_reg[j-1]) >= sh);

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j] <= ge ? (r_reg[j-1] - sh[NUM_W-1:0]) : r_reg[j-1];
                d_reg[j] <= d_reg[j-1];
                q_reg[j] <= q_reg[j-1] | (Q_BITS'(ge) << K);
                n_reg[j] <= n_reg[j-1];
            end
        end
    end

    assign q.neg = n_reg[Q_BITS];
    assign q.mag = q_reg[Q_BITS][Q_BITS-1] ? {1'b1, {(Q_BITS-1){1'b0}}} : q_reg[Q_BITS];

endmodule
`default_nettype wire

// ----- design/hic_error.sv -----
// Error stages: clamped differences, squares, sum, then saturation and threshold test.
// Depends on hic_pkg.
`default_nettype none
module hic_error (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  hic_pkg::quot4_t               pq,
    input  hic_pkg::tgt4_t                tgt,
    input  wire logic                     zero,
    input  wire logic [hic_pkg::ERR_W-1:0] thr,
    output hic_pkg::out_word_t            res
);
    import hic_pkg::*;

    localparam logic [D_W-1:0] CLAMP = D_W'(1) << (CLAMP_W - 1);

    logic [CLAMP_W-1:0] m_reg  [4];
    logic [SQ_W-1:0]    sq_reg [4];
    logic [ACC_W-1:0]   acc_reg;
    logic [2:0]         z_reg;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        logic signed [D_W-1:0] pv;
        logic signed [D_W-1:0] tv;
        logic signed [D_W-1:0] d;
        logic [D_W-1:0]        ad;

        always_comb begin
            pv = pq[i].neg ? -$signed(D_W'(pq[i].mag)) : $signed(D_W'(pq[i].mag));
            tv = $signed(D_W'({tgt[i], 8'b0}));
            d  = tv - pv;
            ad = d[D_W-1] ? D_W'(-d) : D_W'(d);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[i]  <= (ad > CLAMP) ? CLAMP[CLAMP_W-1:0] : ad[CLAMP_W-1:0];
                sq_reg[i] <= SQ_W'(m_reg[i]) * SQ_W'(m_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= ACC_W'(sq_reg[0]) + ACC_W'(sq_reg[1])
                     + ACC_W'(sq_reg[2]) + ACC_W'(sq_reg[3]);
            z_reg   <= {z_reg[1:0], zero};
        end
    end

    logic ovf;
    assign ovf = |acc_reg[ACC_W-1:ERR_W+8];

    always_comb begin
        res.squared_error = (z_reg[2] || ovf) ? '1 : acc_reg[ERR_W+7:8];
        res.inlier        = !z_reg[2] && (res.squared_error < thr);
    end

endmodule
`default_nettype wire
